[hdl/fadd_pkg.sv]
package fadd_pkg;

  localparam int QueueDepth = 2;

  localparam logic [31:0] CodeNan    = 32'h7F800001;
  localparam logic [31:0] CodeDenorm = 32'h00000001;
  localparam logic [31:0] CodePinf   = 32'h7F800000;
  localparam logic [31:0] CodeNinf   = 32'hFF800000;
  localparam logic [31:0] CodeNzero  = 32'h80000000;

  typedef enum logic [2:0] {
    ST_NORMAL    = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_NAN       = 3'd3,
    ST_DENORM    = 3'd4
  } status_t;

  // Work handed from the front to the back. When special is set the result is
  // already known; otherwise the aligned operands are added.
  typedef struct packed {
    logic        special;
    logic [31:0] spec_bits;
    status_t     spec_status;
    logic        sa;
    logic        sb;
    logic [7:0]  ea;
    logic [26:0] ma;   // hidden bit, 23 fraction bits, 3 zero bits
    logic [26:0] mb;   // aligned smaller operand, sticky in bit 0
  } work_t;

  typedef struct packed {
    logic [31:0] bits;
    status_t     status;
  } result_t;

endpackage

[hdl/binary32_float_adder.sv]
// Single-precision adder on stream channels, round to nearest even.
// Slave channel: s_axis_tdata holds operand_a in [31:0] and operand_b in
// [63:32]. Master channel: m_axis_tdata holds sum_bits in [31:0] and status
// in [34:32] (0 normal, 1 underflow, 2 overflow, 3 NaN, 4 denormal input).
// A transfer takes place when tvalid and tready are both high.
// The front stage classifies the operands and aligns the smaller mantissa;
// a two-entry queue feeds the back, which adds in one stage and normalizes,
// rounds and packs in the next, into the output register.
// One pair is accepted per cycle while the output is taken; the
// throughput is set by the output register, one result per cycle.
// When the receiver stalls, the back stages and queue fill and s_axis_tready
// drops once every stage holds an item; nothing is lost.
// The synchronous reset empties all stages and the queue.
module binary32_float_adder #(
  parameter int QueueDepth = fadd_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // operand_a, operand_b
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // sum_bits, status, zero fill
);
  import fadd_pkg::*;

  work_t   f_work, q_work;
  logic    f_valid, f_ready, q_valid, q_ready;
  result_t res;

  fadd_front u_front (
    .clk, .rst,
    .operand_a(s_axis_tdata[31:0]),
    .operand_b(s_axis_tdata[63:32]),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .work(f_work), .work_valid(f_valid), .work_ready(f_ready)
  );

  fadd_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst,
    .wr_data(f_work), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_data(q_work), .rd_valid(q_valid), .rd_ready(q_ready)
  );

  fadd_back u_back (
    .clk, .rst,
    .work(q_work), .work_valid(q_valid), .work_ready(q_ready),
    .res(res), .res_valid(m_axis_tvalid), .res_ready(m_axis_tready)
  );

  assign m_axis_tdata = {5'd0, res.status, res.bits};

endmodule

[hdl/fadd_front.sv]
module fadd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic [31:0]        operand_a,
  input  logic [31:0]        operand_b,
  input  logic               in_valid,
  output logic               in_ready,
  output fadd_pkg::work_t    work,
  output logic               work_valid,
  input  logic               work_ready
);
  import fadd_pkg::*;

  logic [7:0]  ea, eb;
  logic [22:0] fa, fb;
  logic za, zb, da, db, ia, ib, na, nb;
  logic swap;
  logic [7:0]  gap;
  logic [26:0] mbig, msml, shifted;
  logic        lost;
  work_t       w;

  always_comb begin
    ea = operand_a[30:23]; eb = operand_b[30:23];
    fa = operand_a[22:0];  fb = operand_b[22:0];
    za = (ea == 8'd0) && (fa == 23'd0);
    zb = (eb == 8'd0) && (fb == 23'd0);
    da = (ea == 8'd0) && (fa != 23'd0);
    db = (eb == 8'd0) && (fb != 23'd0);
    ia = (ea == 8'hFF) && (fa == 23'd0);
    ib = (eb == 8'hFF) && (fb == 23'd0);
    na = (ea == 8'hFF) && (fa != 23'd0);
    nb = (eb == 8'hFF) && (fb != 23'd0);

    swap = eb > ea;
    gap  = swap ? (eb - ea) : (ea - eb);
    mbig = swap ? {1'b1, fb, 3'b000} : {1'b1, fa, 3'b000};
    msml = swap ? {1'b1, fa, 3'b000} : {1'b1, fb, 3'b000};
    // Bits shifted past the guard positions only matter as a sticky bit.
    if (gap >= 8'd27) begin
      shifted = 27'd0;
      lost = 1'b1;
    end else begin
      shifted = msml >> gap[4:0];
      lost = (msml & ((27'd1 << gap[4:0]) - 27'd1)) != 27'd0;
    end

    w = '0;
    w.sa = swap ? operand_b[31] : operand_a[31];
    w.sb = swap ? operand_a[31] : operand_b[31];
    w.ea = swap ? eb : ea;
    w.ma = mbig;
    w.mb = shifted | {26'd0, lost};
    w.special = 1'b1;
    w.spec_status = ST_NORMAL;
    if (za || zb) begin
      if (za && zb) w.spec_bits = (operand_a[31] && operand_b[31]) ? CodeNzero : 32'd0;
      else if (da || db) begin
        w.spec_bits = CodeDenorm; w.spec_status = ST_DENORM;
      end else if (na || nb) begin
        w.spec_bits = CodeNan; w.spec_status = ST_NAN;
      end else w.spec_bits = za ? operand_b : operand_a;
    end else if (da || db) begin
      if (ia) w.spec_bits = operand_a;
      else if (ib) w.spec_bits = operand_b;
      else if (na || nb) begin
        w.spec_bits = CodeNan; w.spec_status = ST_NAN;
      end else begin
        w.spec_bits = CodeDenorm; w.spec_status = ST_DENORM;
      end
    end else if (ia || ib) begin
      if (na || nb || (ia && ib && (operand_a[31] != operand_b[31]))) begin
        w.spec_bits = CodeNan; w.spec_status = ST_NAN;
      end else w.spec_bits = ia ? operand_a : operand_b;
    end else if (na || nb) begin
      w.spec_bits = CodeNan; w.spec_status = ST_NAN;
    end else begin
      w.special = 1'b0;
      w.spec_bits = 32'd0;
    end
  end

  assign in_ready = !work_valid || work_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else if (in_ready) begin
      work_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      work <= w;
    end
  end

endmodule

[hdl/fadd_queue.sv]
module fadd_queue #(
  parameter int Depth = fadd_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst,
  input  fadd_pkg::work_t wr_data,
  input  logic            wr_valid,
  output logic            wr_ready,
  output fadd_pkg::work_t rd_data,
  output logic            rd_valid,
  input  logic            rd_ready
);
  import fadd_pkg::*;

  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  work_t            mem [Depth];
  logic [AddrW-1:0] wptr, rptr;
  logic [CntW-1:0]  count;
  logic             push, pop;

  assign wr_ready = count != CntW'(Depth);
  assign rd_valid = count != '0;
  assign rd_data  = mem[rptr];
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == AddrW'(Depth - 1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == AddrW'(Depth - 1)) ? '0 : rptr + 1'b1;
      count <= count + CntW'(push) - CntW'(pop);
    end
    if (push) mem[wptr] <= wr_data;
  end

endmodule

[hdl/fadd_back.sv]
module fadd_back (
  input  logic              clk,
  input  logic              rst,
  input  fadd_pkg::work_t   work,
  input  logic              work_valid,
  output logic              work_ready,
  output fadd_pkg::result_t res,
  output logic              res_valid,
  input  logic              res_ready
);
  import fadd_pkg::*;

  // Stage 1: add or subtract the aligned magnitudes.
  logic        s1_valid, s1_special, s1_sign;
  logic [31:0] s1_bits;
  status_t     s1_status;
  logic [7:0]  s1_exp;
  logic [27:0] s1_sum;
  logic        s1_adv, s2_adv;

  logic [27:0] sum_c;
  logic        sign_c;

  always_comb begin
    if (work.sa == work.sb) begin
      sum_c = {1'b0, work.ma} + {1'b0, work.mb};
      sign_c = work.sa;
    end else if (work.ma >= work.mb) begin
      sum_c = {1'b0, work.ma - work.mb};
      sign_c = work.sa;
    end else begin
      sum_c = {1'b0, work.mb - work.ma};
      sign_c = work.sb;
    end
  end

  assign s2_adv = !res_valid || res_ready;
  assign s1_adv = !s1_valid || s2_adv;
  assign work_ready = s1_adv;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (s1_adv) s1_valid <= work_valid;
    if (s1_adv && work_valid) begin
      s1_special <= work.special;
      s1_bits    <= work.spec_bits;
      s1_status  <= work.spec_status;
      s1_sign    <= sign_c;
      s1_exp     <= work.ea;
      s1_sum     <= sum_c;
    end
  end

  // Stage 2: normalize, round and pack.
  logic [4:0]  lz;
  logic        found;
  logic [27:0] norm;
  logic [9:0]  e;
  logic [24:0] mant;
  logic        guard, sticky;
  result_t     r;

  always_comb begin
    lz = 5'd0;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found && s1_sum[i]) begin
        found = 1'b1;
        lz = 5'(26 - i);
      end
    end
    if (s1_sum[27]) begin
      norm = {1'b0, s1_sum[27:2], s1_sum[1] | s1_sum[0]};
      e = {2'b00, s1_exp} + 10'd1;
    end else begin
      norm = s1_sum << lz;
      e = {2'b00, s1_exp} - {5'd0, lz};
    end
    mant   = {1'b0, norm[26:3]};
    guard  = norm[2];
    sticky = norm[1] | norm[0];
    if (guard && (sticky || mant[0])) mant = mant + 25'd1;

    r.bits = 32'd0;
    r.status = ST_NORMAL;
    if (s1_special) begin
      r.bits = s1_bits;
      r.status = s1_status;
    end else if (s1_sum == 28'd0) begin
      r.bits = 32'd0;
    end else if (e[9] || e == 10'd0) begin
      r.status = ST_UNDERFLOW;
    end else if (e >= 10'd255 || (mant[24] && e == 10'd254)) begin
      r.bits = s1_sign ? CodeNinf : CodePinf;
      r.status = ST_OVERFLOW;
    end else if (mant[24]) begin
      r.bits = {s1_sign, 8'(e + 10'd1), mant[23:1]};
    end else begin
      r.bits = {s1_sign, e[7:0], mant[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (s2_adv) res_valid <= s1_valid;
    if (s2_adv && s1_valid) res <= r;
  end

endmodule

[hdl/fadd_checker.sv]
module fadd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  import fadd_pkg::*;

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[34:32] <= ST_DENORM)
    else $error("status code out of range");

  a_nan_code: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[34:32] == ST_NAN) |-> m_axis_tdata[31:0] == CodeNan)
    else $error("NaN status without canonical NaN");

  a_underflow_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[34:32] == ST_UNDERFLOW) |-> m_axis_tdata[31:0] == 32'd0)
    else $error("underflow not flushed to zero");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind binary32_float_adder fadd_checker u_fadd_checker (
  .clk, .rst, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

[dv/fadd_checker.sv]
`timescale 1ns / 1ps

module fadd_sum_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // operand_a, operand_b
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // sum_bits, status, zero fill
  output int          fail_count,
  output int          pending_sums,
  output int          sums_checked
);
  import fadd_pkg::*;

  typedef enum int {
    K_ZERO, K_DENORM, K_INF, K_NAN, K_NORMAL
  } kind_t;

  result_t expected_sums[$];

  function automatic kind_t kind_of(logic [31:0] v);
    if (v[30:23] == 8'h00) return (v[22:0] == 23'd0) ? K_ZERO : K_DENORM;
    if (v[30:23] == 8'hFF) return (v[22:0] == 23'd0) ? K_INF : K_NAN;
    return K_NORMAL;
  endfunction

  function automatic result_t pack_sum(logic [31:0] bits, status_t st);
    result_t r;
    r.bits = bits;
    r.status = st;
    return r;
  endfunction

  function automatic result_t add_normal_pair(logic [31:0] a, logic [31:0] b);
    logic [7:0] ea, eb, tmp_e;
    logic sa, sb, tmp_s, sign, guard, sticky;
    logic [63:0] ma, mb, x, y, s, mant;
    int unsigned gap;
    int e;
    ea = a[30:23];
    eb = b[30:23];
    sa = a[31];
    sb = b[31];
    ma = {40'd0, 1'b1, a[22:0]};
    mb = {40'd0, 1'b1, b[22:0]};
    if (eb > ea) begin
      tmp_e = ea; ea = eb; eb = tmp_e;
      tmp_s = sa; sa = sb; sb = tmp_s;
      x = ma; ma = mb; mb = x;
    end
    gap = 32'(ea) - 32'(eb);
    x = ma << 38;
    y = mb << 38;
    if (gap >= 63) begin
      y = 64'd1;
    end else if (gap > 0) begin
      // Bits shifted out of the smaller operand collapse into a sticky bit.
      sticky = (y & ((64'd1 << gap) - 64'd1)) != 64'd0;
      y = y >> gap;
      if (sticky) y[0] = 1'b1;
    end
    if (sa == sb) begin
      s = x + y;
      sign = sa;
    end else if (x >= y) begin
      s = x - y;
      sign = sa;
    end else begin
      s = y - x;
      sign = sb;
    end
    if (s == 64'd0) return pack_sum(32'd0, ST_NORMAL);
    e = int'(ea);
    if (s[62]) begin
      s = (s >> 1) | (s & 64'd1);
      e++;
    end else begin
      while (!s[61]) begin
        s = s << 1;
        e--;
      end
    end
    if (e <= 0) return pack_sum(32'd0, ST_UNDERFLOW);
    if (e >= 255) return pack_sum(sign ? CodeNinf : CodePinf, ST_OVERFLOW);
    mant = s >> 38;
    guard = s[37];
    sticky = s[36:0] != 37'd0;
    if (guard && (sticky || mant[0])) mant++;
    if (mant[24]) begin
      mant = mant >> 1;
      e++;
      if (e >= 255) return pack_sum(sign ? CodeNinf : CodePinf, ST_OVERFLOW);
    end
    return pack_sum({sign, e[7:0], mant[22:0]}, ST_NORMAL);
  endfunction

  function automatic result_t predict_sum(logic [31:0] a, logic [31:0] b);
    kind_t ka, kb, ko;
    ka = kind_of(a);
    kb = kind_of(b);
    if (ka == K_ZERO || kb == K_ZERO) begin
      if (ka == K_ZERO && kb == K_ZERO)
        return pack_sum((a[31] && b[31]) ? CodeNzero : 32'd0, ST_NORMAL);
      ko = (ka == K_ZERO) ? kb : ka;
      if (ko == K_DENORM) return pack_sum(CodeDenorm, ST_DENORM);
      if (ko == K_NAN) return pack_sum(CodeNan, ST_NAN);
      return pack_sum((ka == K_ZERO) ? b : a, ST_NORMAL);
    end
    if (ka == K_DENORM || kb == K_DENORM) begin
      if (ka == K_INF) return pack_sum(a, ST_NORMAL);
      if (kb == K_INF) return pack_sum(b, ST_NORMAL);
      if (ka == K_NAN || kb == K_NAN) return pack_sum(CodeNan, ST_NAN);
      return pack_sum(CodeDenorm, ST_DENORM);
    end
    if (ka == K_INF || kb == K_INF) begin
      if (ka == K_NAN || kb == K_NAN) return pack_sum(CodeNan, ST_NAN);
      if (ka == K_INF && kb == K_INF)
        return (a[31] == b[31]) ? pack_sum(a, ST_NORMAL) : pack_sum(CodeNan, ST_NAN);
      return pack_sum((ka == K_INF) ? a : b, ST_NORMAL);
    end
    if (ka == K_NAN || kb == K_NAN) return pack_sum(CodeNan, ST_NAN);
    return add_normal_pair(a, b);
  endfunction

  assign pending_sums = expected_sums.size();

  always_ff @(posedge clk) begin
    result_t want;
    if (rst) begin
      fail_count <= 0;
      sums_checked <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_sums.push_back(predict_sum(s_axis_tdata[31:0], s_axis_tdata[63:32]));
      if (m_axis_tvalid && m_axis_tready) begin
        sums_checked <= sums_checked + 1;
        if (expected_sums.size() == 0) begin
          $error("unexpected result transfer: sum_bits %h", m_axis_tdata[31:0]);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_sums.pop_front();
          if (m_axis_tdata[31:0] !== want.bits) begin
            $error("sum_bits: expected %h, actual %h", want.bits, m_axis_tdata[31:0]);
            fail_count <= fail_count + 1;
          end else if (m_axis_tdata[34:32] !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, m_axis_tdata[34:32]);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[dv/tb_binary32_float_adder.sv]
`timescale 1ns / 1ps

module tb_binary32_float_adder;
  import fadd_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // operand_a, operand_b
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // sum_bits, status, zero fill
  int          fail_count, pending_sums, sums_checked;
  int          send_idle_pct, take_idle_pct;
  int          leftover;

  binary32_float_adder DUT (.*);

  fadd_sum_checker sum_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random with the current percentage.
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= take_idle_pct);
  end

  function automatic logic [31:0] random_operand();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(9))
      0: v[30:23] = 8'h00;
      1: v[30:23] = 8'hFF;
      2: v[22:0] = 23'd0;
      3: v[30:23] = 8'($urandom_range(1, 3));
      4: v[30:23] = 8'($urandom_range(252, 254));
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_pair(logic [31:0] a, logic [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {b, a};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic send_random_pair();
    logic [31:0] a, b;
    a = random_operand();
    b = random_operand();
    // Near operands exercise cancellation and rounding ties.
    if ($urandom_range(3) == 0) begin
      b = a + $urandom_range(0, 4) - 2;
      if ($urandom_range(1)) b[31] = ~b[31];
    end
    send_pair(a, b);
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    send_idle_pct = 0;
    take_idle_pct = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_pair(32'h00000000, 32'h00000000);
    send_pair(32'h80000000, 32'h80000000);
    send_pair(32'h80000000, 32'h00000000);
    send_pair(32'h00000000, 32'h3F800000);
    send_pair(32'h00000000, 32'h00400000);
    send_pair(32'h80000000, 32'h7FC00000);
    send_pair(32'h007FFFFF, 32'h3F800000);
    send_pair(32'h00000001, 32'hFF800000);
    send_pair(32'h00000001, 32'h7F800001);
    send_pair(32'h7F800000, 32'h7F800000);
    send_pair(32'h7F800000, 32'hFF800000);
    send_pair(32'hFF800000, 32'h3F800000);
    send_pair(32'h7F800000, 32'hFFFFFFFF);
    send_pair(32'h3F800000, 32'h7FFFFFFF);
    send_pair(32'h3F800000, 32'hBF800000);
    send_pair(32'h7F7FFFFF, 32'h7F7FFFFF);
    send_pair(32'h7F7FFFFF, 32'h73800000);
    send_pair(32'h00800001, 32'h80800000);
    send_pair(32'h3F800000, 32'h33800000);
    send_pair(32'h3F800001, 32'h33800000);
    send_pair(32'h3F800000, 32'h00800000);
    send_pair(32'hFFFFFFFF, 32'h00000000);

    send_idle_pct = 19;
    take_idle_pct = 76;
    repeat (700) send_random_pair();
    send_idle_pct = 76;
    take_idle_pct = 19;
    repeat (700) send_random_pair();
    send_idle_pct = 0;
    take_idle_pct = 0;
    repeat (600) send_random_pair();
    s_axis_tvalid <= 1'b0;

    while (pending_sums != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    leftover = pending_sums;
    $display("Checked %0d sums: special classes, rounding, cancellation, overflow,",
             sums_checked);
    $display("and underflow under sender and receiver stalls.");
    if (fail_count == 0 && leftover == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end
endmodule

[binary32_float_adder.f]
hdl/fadd_pkg.sv
hdl/fadd_front.sv
hdl/fadd_queue.sv
hdl/fadd_back.sv
hdl/binary32_float_adder.sv
hdl/fadd_checker.sv
dv/fadd_checker.sv
dv/tb_binary32_float_adder.sv
